FILE: design/linear_delta_inverse_kinematics_assert.svh
// Assertion macros shared by the kinematics block.
// Every property is sampled on clk_i and switched off while rst_ni is low.
`ifndef LINEAR_DELTA_INVERSE_KINEMATICS_ASSERT_SVH
`define LINEAR_DELTA_INVERSE_KINEMATICS_ASSERT_SVH

// Same-cycle implication.
`define LDIK_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication that matures a fixed number of cycles later.
`define LDIK_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

FILE: design/ldik_pkg.sv
package ldik_pkg;

  // Default coordinate width.
  localparam int unsigned COORD_BITS_DEF = 19;

  // Squared arm length and its floor root.
  localparam int unsigned ARM_BITS  = 40;
  localparam int unsigned ROOT_BITS = ARM_BITS / 2;

  // Configuration port: 64-bit data, registers every 8 bytes.
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned CFG_ADDR_BITS = 6;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_IDX_LSB   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TOWER_A_X = 3'd0,
    REG_TOWER_A_Y = 3'd1,
    REG_TOWER_B_X = 3'd2,
    REG_TOWER_B_Y = 3'd3,
    REG_TOWER_C_X = 3'd4,
    REG_TOWER_C_Y = 3'd5,
    REG_ARM_LEN_SQ = 3'd6
  } cfg_reg_e;

endpackage

FILE: design/ldik_sqrt.sv
module ldik_sqrt (
  input  logic                           clk_i,
  input  logic [ldik_pkg::ARM_BITS-1:0]  rad_i,
  output logic [ldik_pkg::ROOT_BITS-1:0] root_o
);
  import ldik_pkg::*;

  // Digit-by-digit floor square root, one root bit per register stage.
  localparam int unsigned REM_BITS = ROOT_BITS + 1;
  localparam int unsigned CUR_BITS = ROOT_BITS + 3;

  logic [REM_BITS-1:0]  rem_q  [ROOT_BITS-1];
  logic [ARM_BITS-1:0]  n_q    [ROOT_BITS-1];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];

  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
    logic [REM_BITS-1:0]  rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [ARM_BITS-1:0]  n_in;
    logic [CUR_BITS-1:0]  cur;
    logic [CUR_BITS-1:0]  trial;
    logic [CUR_BITS-1:0]  diff;
    logic                 ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign n_in    = n_q[s-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign cur   = {rem_in, n_in[ARM_BITS-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);
    assign diff  = cur - trial;

    always_ff @(posedge clk_i) begin
      root_q[s] <= {root_in[ROOT_BITS-2:0], ge};
    end

    if (s < ROOT_BITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? diff[REM_BITS-1:0] : cur[REM_BITS-1:0];
        n_q[s]   <= {n_in[ARM_BITS-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ROOT_BITS-1];

endmodule

FILE: design/linear_delta_inverse_kinematics.sv
// Channel   Direction  Handshake                    Payload
// config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
// position  in         start, busy                  pos_x_i, pos_y_i, pos_z_i
// carriage  out        done_o                       carriage_a_o .. _c_o, unreachable_o
//
// A position beat is taken at every clock edge with start high; busy is always low.
// Each beat leaves as one carriage beat after passing the differences, squares
// and radicand stages, one stage per root bit in the square root pipelines,
// and the output register.
// The result is shown for one cycle with done_o high and the receiver cannot stall.
// Reset clears the valid bits and the configuration registers, which read as zero.
`include "linear_delta_inverse_kinematics_assert.svh"

module linear_delta_inverse_kinematics #(
  parameter int unsigned COORD_BITS = ldik_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ldik_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [ldik_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [ldik_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  // Effector position
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  input  logic signed [COORD_BITS-1:0]        pos_z_i,
  // Carriage positions
  output logic                                done_o,
  output logic signed [COORD_BITS+2:0]        carriage_a_o,
  output logic signed [COORD_BITS+2:0]        carriage_b_o,
  output logic signed [COORD_BITS+2:0]        carriage_c_o,
  output logic                                unreachable_o
);
  import ldik_pkg::*;

  localparam int unsigned OUT_BITS = COORD_BITS + 3;
  localparam int unsigned SQ_BITS  = 2 * COORD_BITS + 1;
  localparam int unsigned SQS_BITS = 2 * COORD_BITS + 2;
  localparam int unsigned RAD_BITS = ((ARM_BITS > SQS_BITS) ? ARM_BITS : SQS_BITS) + 1;
  localparam int unsigned SUM_BITS = ((ROOT_BITS + 2) > OUT_BITS) ? (ROOT_BITS + 2) : OUT_BITS;
  localparam int unsigned LATENCY  = ROOT_BITS + 4;
  localparam int unsigned NUM_TOWERS = 3;

  // ---------------------------------------------------------------------------
  // Configuration registers. Tower coordinates are kept as signed values at the
  // coordinate width; the arm length squared is a plain 40-bit value. Writes to
  // the unused eighth slot are dropped and it reads as zero.
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] twr_x_q [NUM_TOWERS];
  logic signed [COORD_BITS-1:0] twr_y_q [NUM_TOWERS];
  logic [ARM_BITS-1:0]          arm_q;
  logic                         cfg_wr;
  cfg_reg_e                     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_reg_e'(paddr[CFG_IDX_LSB +: CFG_IDX_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TOWERS; t++) begin
        twr_x_q[t] <= '0;
        twr_y_q[t] <= '0;
      end
      arm_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TOWER_A_X:  twr_x_q[0] <= pwdata[COORD_BITS-1:0];
        REG_TOWER_A_Y:  twr_y_q[0] <= pwdata[COORD_BITS-1:0];
        REG_TOWER_B_X:  twr_x_q[1] <= pwdata[COORD_BITS-1:0];
        REG_TOWER_B_Y:  twr_y_q[1] <= pwdata[COORD_BITS-1:0];
        REG_TOWER_C_X:  twr_x_q[2] <= pwdata[COORD_BITS-1:0];
        REG_TOWER_C_Y:  twr_y_q[2] <= pwdata[COORD_BITS-1:0];
        REG_ARM_LEN_SQ: arm_q      <= pwdata[ARM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read data is the raw register contents, zero extended.
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_TOWER_A_X:  prdata[COORD_BITS-1:0] = twr_x_q[0];
      REG_TOWER_A_Y:  prdata[COORD_BITS-1:0] = twr_y_q[0];
      REG_TOWER_B_X:  prdata[COORD_BITS-1:0] = twr_x_q[1];
      REG_TOWER_B_Y:  prdata[COORD_BITS-1:0] = twr_y_q[1];
      REG_TOWER_C_X:  prdata[COORD_BITS-1:0] = twr_x_q[2];
      REG_TOWER_C_Y:  prdata[COORD_BITS-1:0] = twr_y_q[2];
      REG_ARM_LEN_SQ: prdata[ARM_BITS-1:0]   = arm_q;
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. There is no back pressure, so a beat is taken whenever
  // start is high and every stage moves on each cycle. The valid bit and the
  // z coordinate ride along with the lane data.
  // ---------------------------------------------------------------------------
  assign busy = 1'b0;

  logic                         s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [COORD_BITS-1:0] s1_z_q, s2_z_q, s3_z_q;
  logic                         s3_bad_d, s3_bad_q;
  logic                         sd_vld_q [ROOT_BITS];
  logic signed [COORD_BITS-1:0] sd_z_q   [ROOT_BITS];
  logic                         sd_bad_q [ROOT_BITS];

  // Per tower lane: difference, square, radicand, root.
  logic signed [COORD_BITS:0]   dx_q    [NUM_TOWERS];
  logic signed [COORD_BITS:0]   dy_q    [NUM_TOWERS];
  logic [SQ_BITS-1:0]           sqx_q   [NUM_TOWERS];
  logic [SQ_BITS-1:0]           sqy_q   [NUM_TOWERS];
  logic [ARM_BITS-1:0]          rad_q   [NUM_TOWERS];
  logic [NUM_TOWERS-1:0]        neg;
  logic [ROOT_BITS-1:0]         root    [NUM_TOWERS];
  logic signed [OUT_BITS-1:0]   car_d   [NUM_TOWERS];
  logic signed [OUT_BITS-1:0]   car_q   [NUM_TOWERS];

  for (genvar t = 0; t < NUM_TOWERS; t++) begin : g_lane
    logic signed [COORD_BITS:0]   dx_d, dy_d;
    logic signed [SQS_BITS-1:0]   px, py;
    logic signed [RAD_BITS-1:0]   rad_full;
    logic signed [SUM_BITS-1:0]   sum;

    // Stage 1: offsets from the tower, one bit wider than a coordinate.
    assign dx_d = $signed({twr_x_q[t][COORD_BITS-1], twr_x_q[t]})
                - $signed({pos_x_i[COORD_BITS-1], pos_x_i});
    assign dy_d = $signed({twr_y_q[t][COORD_BITS-1], twr_y_q[t]})
                - $signed({pos_y_i[COORD_BITS-1], pos_y_i});

    // Stage 2: squares; each is non-negative and fits one bit under the product.
    assign px = dx_q[t] * dx_q[t];
    assign py = dy_q[t] * dy_q[t];

    // Stage 3: radicand. Its sign bit marks an unreachable tower. When it is
    // not negative it cannot exceed the arm length squared, so the low bits
    // are all the root needs.
    assign rad_full = $signed({{(RAD_BITS - ARM_BITS){1'b0}}, arm_q})
                    - $signed({{(RAD_BITS - SQ_BITS){1'b0}}, sqx_q[t]})
                    - $signed({{(RAD_BITS - SQ_BITS){1'b0}}, sqy_q[t]});
    assign neg[t]   = rad_full[RAD_BITS-1];

    always_ff @(posedge clk_i) begin
      dx_q[t]  <= dx_d;
      dy_q[t]  <= dy_d;
      sqx_q[t] <= px[SQ_BITS-1:0];
      sqy_q[t] <= py[SQ_BITS-1:0];
      rad_q[t] <= rad_full[ARM_BITS-1:0];
    end

    ldik_sqrt u_sqrt (
      .clk_i  (clk_i),
      .rad_i  (rad_q[t]),
      .root_o (root[t])
    );

    // Output stage: root plus z, wrapped to the carriage width, or zero when any tower is unreachable.
    assign sum = $signed({{(SUM_BITS - ROOT_BITS){1'b0}}, root[t]})
               + $signed({{(SUM_BITS - COORD_BITS){sd_z_q[ROOT_BITS-1][COORD_BITS-1]}},
                          sd_z_q[ROOT_BITS-1]});
    assign car_d[t] = sd_bad_q[ROOT_BITS-1] ? '0 : sum[OUT_BITS-1:0];

    always_ff @(posedge clk_i) begin
      car_q[t] <= car_d[t];
    end
  end

  assign s3_bad_d = |neg;

  // Valid bits.
  logic done_q, unreach_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      for (int s = 0; s < ROOT_BITS; s++) begin
        sd_vld_q[s] <= 1'b0;
      end
      done_q <= 1'b0;
    end else begin
      s1_vld_q    <= start;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      sd_vld_q[0] <= s3_vld_q;
      for (int s = 1; s < ROOT_BITS; s++) begin
        sd_vld_q[s] <= sd_vld_q[s-1];
      end
      done_q <= sd_vld_q[ROOT_BITS-1];
    end
  end

  // Side data that travels alongside the lanes.
  always_ff @(posedge clk_i) begin
    s1_z_q      <= pos_z_i;
    s2_z_q      <= s1_z_q;
    s3_z_q      <= s2_z_q;
    s3_bad_q    <= s3_bad_d;
    sd_z_q[0]   <= s3_z_q;
    sd_bad_q[0] <= s3_bad_q;
    for (int s = 1; s < ROOT_BITS; s++) begin
      sd_z_q[s]   <= sd_z_q[s-1];
      sd_bad_q[s] <= sd_bad_q[s-1];
    end
    unreach_q <= sd_bad_q[ROOT_BITS-1];
  end

  assign done_o        = done_q;
  assign carriage_a_o  = car_q[0];
  assign carriage_b_o  = car_q[1];
  assign carriage_c_o  = car_q[2];
  assign unreachable_o = unreach_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LDIK_ASSERT_DELAY(a_beat_out, start, LATENCY, done_o, "accepted beat did not come out")
  `LDIK_ASSERT_DELAY(a_no_ghost, !start, LATENCY, !done_o, "result beat without an input")
  `LDIK_ASSERT_IMPLY(a_unreach_zero, done_o && unreachable_o,
                     carriage_a_o == '0 && carriage_b_o == '0 && carriage_c_o == '0,
                     "unreachable result with nonzero carriage")

endmodule

FILE: tb/linear_delta_inverse_kinematics_test.sv
module linear_delta_inverse_kinematics_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ldik_pkg::*;

  localparam int unsigned COORD_BITS = COORD_BITS_DEF;
  localparam int unsigned OUT_BITS = COORD_BITS + 3;
  localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
  localparam logic [CFG_DATA_BITS-1:0] ARM_MAX = (64'd1 << ARM_BITS) - 1;

  // The address one slot past the last register; writes there must be dropped.
  localparam int unsigned REG_UNMAPPED = REG_ARM_LEN_SQ + 1;

  // The delay from taking a position beat until its carriage beat leaves the pipeline.
  localparam int unsigned RESULT_LATENCY = ROOT_BITS + 4;
  localparam int unsigned DRAIN_LIMIT = 4 * RESULT_LATENCY;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam realtime CLK_PERIOD = 10ns;

  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  // One carriage beat as the block should present it.
  typedef struct {
    logic signed [OUT_BITS-1:0] carriage[3];
    logic                       unreachable;
  } carriage_set_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic                         start = 1'b0;
  logic                         busy;
  logic signed [COORD_BITS-1:0] pos_x_i = '0;
  logic signed [COORD_BITS-1:0] pos_y_i = '0;
  logic signed [COORD_BITS-1:0] pos_z_i = '0;

  logic                       done_o;
  logic signed [OUT_BITS-1:0] carriage_a_o;
  logic signed [OUT_BITS-1:0] carriage_b_o;
  logic signed [OUT_BITS-1:0] carriage_c_o;
  logic                       unreachable_o;

  // Local copy of the configuration registers, updated at the same clock edge
  // at which the block takes each write.
  logic signed [COORD_BITS-1:0] tower_x[3] = '{default: '0};
  logic signed [COORD_BITS-1:0] tower_y[3] = '{default: '0};
  logic [ARM_BITS-1:0]          arm_sq = '0;

  // Carriage beats still owed by the block, oldest first.
  carriage_set_t pending_carriages[$];

  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  bit          steady_stream = 1'b0;

  string carriage_name[3] = '{"carriage_a", "carriage_b", "carriage_c"};

  carriage_set_t              due_carriages;
  logic signed [OUT_BITS-1:0] seen_carriage[3];

  linear_delta_inverse_kinematics #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .done_o       (done_o),
    .carriage_a_o (carriage_a_o),
    .carriage_b_o (carriage_b_o),
    .carriage_c_o (carriage_c_o),
    .unreachable_o(unreachable_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Hard stop in case the block hangs or never produces a result.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[linear_delta_inverse_kinematics] ERROR");
      $finish;
    end
  end

  // Works out the carriage beat for one effector position from the local
  // copy of the registers. The distance to each tower is taken exactly, the
  // radicand is checked for sign, and the floor root is built one bit at a
  // time from the top, keeping a bit whenever its square still fits.
  function automatic carriage_set_t solve_carriages(logic signed [COORD_BITS-1:0] x,
                                                    logic signed [COORD_BITS-1:0] y,
                                                    logic signed [COORD_BITS-1:0] z);
    carriage_set_t res;
    longint        radicand[3];
    longint        dx;
    longint        dy;
    longint        root;
    longint        trial;
    int            t;
    int            b;
    bit            out_of_reach;
    out_of_reach = 1'b0;
    for (t = 0; t < 3; t++) begin
      dx = longint'(tower_x[t]) - longint'(x);
      dy = longint'(tower_y[t]) - longint'(y);
      radicand[t] = longint'({24'b0, arm_sq}) - dx * dx - dy * dy;
      if (radicand[t] < 0) out_of_reach = 1'b1;
    end
    // A single tower out of reach zeroes all three carriages.
    res.unreachable = out_of_reach;
    for (t = 0; t < 3; t++) begin
      if (out_of_reach) begin
        res.carriage[t] = '0;
      end else begin
        root = 0;
        for (b = ROOT_BITS - 1; b >= 0; b--) begin
          trial = root | (longint'(1) << b);
          if (trial * trial <= radicand[t]) root = trial;
        end
        res.carriage[t] = OUT_BITS'(root + longint'(z));
      end
    end
    return res;
  endfunction

  // Uniform value in [-half, half - 1].
  function automatic int rand_span(int half);
    return int'($urandom_range(0, 2 * half - 1)) - half;
  endfunction

  // Result checker. The receiver cannot stall, so every cycle with done_o high
  // is one carriage beat; it is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_carriages.size() == 0) begin
        $error("carriage beat with no position beat outstanding");
        failures++;
      end else begin
        due_carriages = pending_carriages.pop_front();
        seen_carriage[0] = carriage_a_o;
        seen_carriage[1] = carriage_b_o;
        seen_carriage[2] = carriage_c_o;
        for (int t = 0; t < 3; t++) begin
          if (seen_carriage[t] !== due_carriages.carriage[t]) begin
            $error("%s: expected %0d, got %0d", carriage_name[t],
                   due_carriages.carriage[t], seen_carriage[t]);
            failures++;
          end
        end
        if (unreachable_o !== due_carriages.unreachable) begin
          $error("unreachable: expected %0d, got %0d", due_carriages.unreachable,
                 unreachable_o);
          failures++;
        end
      end
    end
  end

  // Sends one position beat. Before it the sender idles for a random number
  // of cycles, unless a steady stream is asked for, and drives junk on the
  // payload while start is low so that the block must ignore it.
  task automatic send_position(int x, int y, int z);
    int gap;
    gap = steady_stream ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) begin
        pos_x_i <= COORD_BITS'($urandom);
        pos_y_i <= COORD_BITS'($urandom);
        pos_z_i <= COORD_BITS'($urandom);
        @(posedge clk_i);
      end
    end
    start   <= 1'b1;
    pos_x_i <= x[COORD_BITS-1:0];
    pos_y_i <= y[COORD_BITS-1:0];
    pos_z_i <= z[COORD_BITS-1:0];
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_carriages.push_back(solve_carriages(x[COORD_BITS-1:0], y[COORD_BITS-1:0],
                                                z[COORD_BITS-1:0]));
  endtask

  // Ends the current burst and waits for every outstanding carriage beat.
  // Anything still owed after a generous wait is reported as missing.
  task automatic wait_for_carriages();
    int unsigned w;
    start <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && pending_carriages.size() != 0; w++)
      @(posedge clk_i);
    if (pending_carriages.size() != 0) begin
      $error("carriage: %0d expected beats never arrived", pending_carriages.size());
      failures += pending_carriages.size();
      pending_carriages.delete();
    end
  endtask

  // One bus write: setup cycle, then access cycle until pready, then an idle
  // cycle. The local copy is updated at the edge that commits the write, with
  // the bits above each register's width dropped as the block must do.
  task automatic program_register(int unsigned idx, logic [CFG_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx << CFG_IDX_LSB);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_TOWER_A_X:  tower_x[0] = value[COORD_BITS-1:0];
      REG_TOWER_A_Y:  tower_y[0] = value[COORD_BITS-1:0];
      REG_TOWER_B_X:  tower_x[1] = value[COORD_BITS-1:0];
      REG_TOWER_B_Y:  tower_y[1] = value[COORD_BITS-1:0];
      REG_TOWER_C_X:  tower_x[2] = value[COORD_BITS-1:0];
      REG_TOWER_C_Y:  tower_y[2] = value[COORD_BITS-1:0];
      REG_ARM_LEN_SQ: arm_sq = value[ARM_BITS-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reads one register back and compares the bits within its width.
  task automatic verify_register(int unsigned idx);
    logic [CFG_DATA_BITS-1:0] want;
    logic [CFG_DATA_BITS-1:0] mask;
    mask = (64'd1 << COORD_BITS) - 1;
    case (idx)
      REG_TOWER_A_X:  want = CFG_DATA_BITS'(tower_x[0]);
      REG_TOWER_A_Y:  want = CFG_DATA_BITS'(tower_y[0]);
      REG_TOWER_B_X:  want = CFG_DATA_BITS'(tower_x[1]);
      REG_TOWER_B_Y:  want = CFG_DATA_BITS'(tower_y[1]);
      REG_TOWER_C_X:  want = CFG_DATA_BITS'(tower_x[2]);
      REG_TOWER_C_Y:  want = CFG_DATA_BITS'(tower_y[2]);
      default: begin
        want = CFG_DATA_BITS'(arm_sq);
        mask = ARM_MAX;
      end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_BITS'(idx << CFG_IDX_LSB);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if ((prdata & mask) !== (want & mask)) begin
      $error("register %0d: expected %0h, got %0h", idx, want & mask, prdata & mask);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprograms the whole geometry while the block is idle. Random junk sits
  // above each value's width, the unmapped slot is sometimes written too,
  // and every register is read back afterwards.
  task automatic configure_towers(int ax, int ay, int bx, int by, int cx, int cy,
                                  logic [CFG_DATA_BITS-1:0] arm);
    int                       coord[6];
    logic [CFG_DATA_BITS-1:0] word;
    int unsigned              idx;
    coord = '{ax, ay, bx, by, cx, cy};
    wait_for_carriages();
    for (idx = REG_TOWER_A_X; idx <= REG_TOWER_C_Y; idx++) begin
      word = {$urandom, $urandom};
      word[COORD_BITS-1:0] = coord[idx][COORD_BITS-1:0];
      program_register(idx, word);
    end
    word = {$urandom, $urandom};
    word[ARM_BITS-1:0] = arm[ARM_BITS-1:0];
    program_register(REG_ARM_LEN_SQ, word);
    if ($urandom_range(0, 1) == 1) program_register(REG_UNMAPPED, {$urandom, $urandom});
    for (idx = REG_TOWER_A_X; idx <= REG_ARM_LEN_SQ; idx++) verify_register(idx);
  endtask

  // With every register at zero only the origin is reachable, and there the
  // carriages simply follow z.
  task automatic test_reset_state();
    int unsigned idx;
    for (idx = REG_TOWER_A_X; idx <= REG_ARM_LEN_SQ; idx++) verify_register(idx);
    send_position(0, 0, 0);
    send_position(0, 0, COORD_MAX);
    send_position(0, 0, COORD_MIN);
    send_position(1, 0, 5);
    send_position(0, -1, 0);
    send_position(COORD_MIN, COORD_MAX, 0);
    send_position(COORD_MAX, COORD_MIN, COORD_MAX);
  endtask

  // A small symmetric machine: towers at 210, 330 and 90 degrees on a radius
  // of 1000 with an arm of 2500. Covers a position right under a tower, a
  // zero radicand, the first position past it and a non-square radicand.
  task automatic test_symmetric_delta();
    configure_towers(-866, -500, 866, -500, 0, 1000, 64'd6250000);
    send_position(0, 0, 0);
    send_position(-866, -500, 100);
    send_position(0, -1500, 0);
    send_position(0, -1501, 0);
    send_position(1, -1500, 7);
    send_position(0, -1499, -3);
    send_position(0, 0, COORD_MAX);
    send_position(0, 0, COORD_MIN);
  endtask

  // Towers in the corners of the coordinate range with the largest arm, so
  // that differences, squares and the root use their full widths; then all
  // towers stacked on one spot with a zero arm.
  task automatic test_extreme_registers();
    configure_towers(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                     ARM_MAX);
    send_position(COORD_MIN, COORD_MIN, COORD_MAX);
    send_position(COORD_MAX, COORD_MAX, COORD_MIN);
    send_position(0, 0, 0);
    send_position(COORD_MAX, COORD_MIN, 0);
    configure_towers(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                     64'd0);
    send_position(COORD_MAX, COORD_MAX, COORD_MIN);
    send_position(COORD_MAX, COORD_MAX - 1, 0);
  endtask

  // Random machines of many sizes. Towers sit in a box of half width span,
  // the arm reaches two to three spans, so most positions inside the box are
  // reachable and some are not. A share of positions is drawn over the whole
  // coordinate range as noise. The first phase uses the full range, the
  // second an arm with random bits throughout.
  task automatic test_random_sweep();
    int unsigned              phase;
    int unsigned              n;
    int                       span;
    longint                   reach;
    logic [CFG_DATA_BITS-1:0] arm;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      span = (phase == 0) ? (1 << (COORD_BITS - 1)) : (1 << $urandom_range(3, COORD_BITS - 1));
      reach = $urandom_range(2 * span, 3 * span);
      arm = (phase == 1) ? {$urandom, $urandom} : 64'(reach * reach + $urandom_range(0, 255));
      configure_towers(rand_span(span), rand_span(span), rand_span(span), rand_span(span),
                       rand_span(span), rand_span(span), arm);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Switch between gapped traffic and back-to-back stretches.
        if (n % 25 == 0) steady_stream = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 85)
          send_position(rand_span(span), rand_span(span), rand_span(1 << (COORD_BITS - 1)));
        else
          send_position($urandom, $urandom, $urandom);
      end
      steady_stream = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_symmetric_delta();
    test_extreme_registers();
    test_random_sweep();

    wait_for_carriages();
    // Let a late or extra beat show up before the verdict.
    repeat (RESULT_LATENCY + 8) @(posedge clk_i);
    if (failures == 0) begin
      $display("[linear_delta_inverse_kinematics] OK");
    end else begin
      $display("[linear_delta_inverse_kinematics] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/ldik_pkg.sv
design/ldik_sqrt.sv
design/linear_delta_inverse_kinematics.sv
tb/linear_delta_inverse_kinematics_test.sv
